// ===== rtl/abkf_pkg.sv =====
`default_nettype none

package abkf_pkg;

  // Default widths of the angle words (Q4.12) and of the covariance/bias words (Q8.24)
  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int COV_WIDTH_DEF   = 32;

  // Fraction bits of the internal working format
  localparam int FRAC = 24;

  // Angle inputs are widened from Q.12 to Q.24 by this shift
  localparam int ANGLE_SHIFT = 12;

  // Signed width of a product after rounding (magnitude limited to 2^52)
  localparam int MAG_LIMIT_BITS = 52;
  localparam int RES_W          = MAG_LIMIT_BITS + 2;

  // Multiplier digit width (bits of the second operand taken per cycle)
  localparam int CHUNK_W = 16;

  // dt = (interval_ms * DT_RECIP + 512) >> 10, in Q.24
  localparam int       MS_W     = 10;
  localparam int       DT_W     = 25;
  localparam int       DT_PW    = 35;
  localparam int       DT_SHIFT = 10;
  localparam int       DT_RND   = 512;
  localparam int       DT_RECIP = 17179869;

  // Configuration port
  localparam int CFG_W      = 24;
  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ANGLE_NOISE = 2'd0,
    REG_BIAS_NOISE  = 2'd1,
    REG_MEAS_NOISE  = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] ANGLE_NOISE_RST = 24'd167772;
  localparam logic [CFG_W-1:0] BIAS_NOISE_RST  = 24'd5033;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST  = 24'd167772;

endpackage

`default_nettype wire

// ===== rtl/abkf_mul.sv =====
`default_nettype none

// Sign-magnitude multiplier, one CHUNK_W digit of b per cycle, MSB digit first.
// Result is round(a*b / 2^24) half away from zero, magnitude limited to 2^52.
module abkf_mul #(
  parameter int OPW = 34
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [OPW-1:0]             a,
  input  wire logic signed [OPW-1:0]             b,
  output logic                                   done,
  output logic signed [abkf_pkg::RES_W-1:0]      result
);
  import abkf_pkg::*;

  localparam int NCH  = (OPW + CHUNK_W - 1) / CHUNK_W;
  localparam int BW   = NCH * CHUNK_W;
  localparam int PW   = OPW + BW;
  localparam int SW   = PW - FRAC;
  localparam int CMPW = (SW > MAG_LIMIT_BITS + 1) ? SW : MAG_LIMIT_BITS + 1;
  localparam int CNTW = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PPW  = OPW + CHUNK_W;

  typedef enum logic [1:0] {M_IDLE, M_ACC, M_RND} mstate_t;

  mstate_t         state;
  logic [OPW-1:0]  amag;
  logic [BW-1:0]   bsh;
  logic [PW-1:0]   acc;
  logic [CNTW-1:0] cnt;
  logic            neg;

  logic [OPW-1:0]        a_u, b_u, a_mag, b_mag;
  logic [PPW-1:0]        pp;
  logic [PW-1:0]         rsum;
  logic [CMPW-1:0]       rcmp, lim, clamped;
  logic [RES_W-1:0]      mag_ext;

  always_comb begin
    a_u     = a;
    b_u     = b;
    a_mag   = a_u[OPW-1] ? (~a_u + OPW'(1)) : a_u;
    b_mag   = b_u[OPW-1] ? (~b_u + OPW'(1)) : b_u;
    pp      = PPW'(amag) * PPW'(bsh[BW-1 -: CHUNK_W]);
    rsum    = acc + (PW'(1) << (FRAC - 1));
    rcmp    = CMPW'(rsum[PW-1:FRAC]);
    lim     = CMPW'(1) << MAG_LIMIT_BITS;
    clamped = (rcmp > lim) ? lim : rcmp;
    mag_ext = {1'b0, clamped[MAG_LIMIT_BITS:0]};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= M_IDLE;
    end else begin
      unique case (state)
        M_IDLE: begin
          if (start) begin
            amag  <= a_mag;
            bsh   <= BW'(b_mag);
            acc   <= '0;
            cnt   <= '0;
            neg   <= a[OPW-1] ^ b[OPW-1];
            state <= M_ACC;
          end
        end
        M_ACC: begin
          acc <= (acc << CHUNK_W) + PW'(pp);
          bsh <= bsh << CHUNK_W;
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(NCH - 1)) begin
            state <= M_RND;
          end
        end
        M_RND: begin
          result <= neg ? -$signed(mag_ext) : $signed(mag_ext);
          done   <= 1'b1;
          state  <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/abkf_div.sv =====
`default_nettype none

// Restoring divider, one quotient bit per cycle: (num << 24) / den,
// truncated toward zero, saturated to CW bits signed. den must be nonzero.
module abkf_div #(
  parameter int CW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [CW-1:0] num,
  input  wire logic signed [CW:0]   den,
  output logic                      done,
  output logic signed [CW-1:0]      result
);
  import abkf_pkg::*;

  localparam int NB   = CW + FRAC;
  localparam int DW   = CW + 2;
  localparam int CNTW = $clog2(NB);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

  localparam logic [CW-1:0] Q_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] Q_MIN = {1'b1, {(CW-1){1'b0}}};

  dstate_t         state;
  logic [NB-1:0]   dvd;
  logic [NB-1:0]   q;
  logic [DW-1:0]   rem;
  logic [CW:0]     dmag;
  logic [CNTW-1:0] cnt;
  logic            neg;

  logic [CW-1:0] num_u, num_mag;
  logic [CW:0]   den_u, den_mag;
  logic [DW-1:0] rs;
  logic          ge;
  logic          big;

  always_comb begin
    num_u   = num;
    den_u   = den;
    num_mag = num_u[CW-1] ? (~num_u + CW'(1)) : num_u;
    den_mag = den_u[CW] ? (~den_u + (CW+1)'(1)) : den_u;
    rs      = {rem[DW-2:0], dvd[NB-1]};
    ge      = rs >= DW'(dmag);
    big     = |q[NB-1:CW-1];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      state <= D_IDLE;
    end else begin
      unique case (state)
        D_IDLE: begin
          if (start) begin
            dvd   <= {num_mag, {FRAC{1'b0}}};
            q     <= '0;
            rem   <= '0;
            dmag  <= den_mag;
            cnt   <= '0;
            neg   <= num[CW-1] ^ den[CW];
            state <= D_RUN;
          end
        end
        D_RUN: begin
          rem <= ge ? (rs - DW'(dmag)) : rs;
          q   <= {q[NB-2:0], ge};
          dvd <= dvd << 1;
          cnt <= cnt + CNTW'(1);
          if (cnt == CNTW'(NB - 1)) begin
            state <= D_FIN;
          end
        end
        D_FIN: begin
          if (big) begin
            result <= neg ? Q_MIN : Q_MAX;
          end else begin
            result <= neg ? -$signed(q[CW-1:0]) : $signed(q[CW-1:0]);
          end
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/angle_bias_kalman_filter_core.sv =====
`default_nettype none
// From accept, a word runs the predict and correct products on the shared multiplier and,
//   unless S is zero, the gain divisions on the divider before its result is posted.
// s_tready is high only while idle, so a new word is taken only once the last one is through. A finished
//   result sits in the output register, so the next word is taken while it waits.
// Reset (rst, synchronous, active high): bias and covariances clear to zero, noise
//   registers take their defaults, no word in flight, m_tvalid low.
module angle_bias_kalman_filter_core #(
  parameter int ANGLE_WIDTH = abkf_pkg::ANGLE_WIDTH_DEF,
  parameter int COV_WIDTH   = abkf_pkg::COV_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // slave word: measured_angle, rate, interval_ms, prior_angle (LSB first), zero padded
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [((3*ANGLE_WIDTH+abkf_pkg::MS_W+7)/8)*8-1:0] s_tdata,
  // master word: angle_out, zero padded
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [((ANGLE_WIDTH+7)/8)*8-1:0]         m_tdata,
  // config write port
  input  wire logic                                cfg_wr_en,
  input  wire logic [abkf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [abkf_pkg::CFG_W-1:0]          cfg_wdata
);
  import abkf_pkg::*;

  localparam int AW  = ANGLE_WIDTH;
  localparam int CW  = COV_WIDTH;
  localparam int XA  = AW + ANGLE_SHIFT;                // working angle, Q.24
  localparam int YW  = XA + 1;                          // innovation
  localparam int OPW = ((XA > CW) ? XA : CW) + 2;       // multiplier operand
  localparam int XW  = RES_W + 3;                       // sum width ahead of saturation
  localparam int ODW = ((AW + 7) / 8) * 8;
  localparam int QW  = XA + 1 - ANGLE_SHIFT;            // rounded output magnitude

  localparam logic signed [XW-1:0] XA_HI = {{(XW-XA+1){1'b0}}, {(XA-1){1'b1}}};
  localparam logic signed [XW-1:0] XA_LO = ~XA_HI;
  localparam logic signed [XW-1:0] CW_HI = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [XW-1:0] CW_LO = ~CW_HI;
  localparam logic [AW-1:0]        OUT_MAX = {1'b0, {(AW-1){1'b1}}};
  localparam logic [AW-1:0]        OUT_MIN = {1'b1, {(AW-1){1'b0}}};
  localparam logic [QW-1:0]        OUT_POS_LIM = QW'(OUT_MAX);
  localparam logic [QW-1:0]        OUT_NEG_LIM = QW'(OUT_MAX) + QW'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_GO, S_MUL_WAIT, S_GAIN, S_DIV_GO, S_DIV_WAIT, S_OUT
  } state_t;

  // Product schedule: predict (M0..M4), then correct (M5..M10)
  typedef enum logic [3:0] {
    OP_M0, OP_M1, OP_M2, OP_M3, OP_M4, OP_M5, OP_M6, OP_M7, OP_M8, OP_M9, OP_M10
  } op_t;

  function automatic logic signed [XA-1:0] sat_xa(input logic signed [XW-1:0] v);
    if (v > XA_HI) sat_xa = XA_HI[XA-1:0];
    else if (v < XA_LO) sat_xa = XA_LO[XA-1:0];
    else sat_xa = v[XA-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [XW-1:0] v);
    if (v > CW_HI) sat_cw = CW_HI[CW-1:0];
    else if (v < CW_LO) sat_cw = CW_LO[CW-1:0];
    else sat_cw = v[CW-1:0];
  endfunction

  // Noise registers
  logic [CFG_W-1:0] q_angle, q_bias, r_meas;

  // Filter state carried between words
  logic signed [CW-1:0] gyro_bias, cov_aa, cov_ab, cov_ba, cov_bb;

  // Per-word working registers
  state_t               state;
  op_t                  op;
  logic                 div_sel;
  logic signed [XA-1:0] meas_q, rate_q, x;
  logic signed [YW-1:0] y;
  logic [DT_W-1:0]      dt;
  logic signed [XW-1:0] tmp;
  logic signed [CW-1:0] p00, p01, p10, p11, k0, k1;
  logic signed [CW:0]   s_den;

  // Shared units
  logic                    mul_start, mul_done;
  logic signed [OPW-1:0]   mul_a, mul_b;
  logic signed [RES_W-1:0] mul_res;
  logic signed [XW-1:0]    mr;
  logic                    div_start, div_done;
  logic signed [CW-1:0]    div_num, div_res;

  // Input unpack and dt
  logic signed [AW-1:0] in_meas, in_rate, in_prior;
  logic [MS_W-1:0]      in_ms;
  logic [DT_PW-1:0]     dt_prod;
  logic signed [OPW-1:0] dt_op;
  logic signed [CW:0]   s_comb;

  // Output rounding
  logic [XA-1:0]   x_u, x_mag;
  logic [XA:0]     x_rnd;
  logic [QW-1:0]   qm;
  logic [AW-1:0]   out_val;

  assign in_meas  = s_tdata[AW-1:0];
  assign in_rate  = s_tdata[2*AW-1:AW];
  assign in_ms    = s_tdata[2*AW+MS_W-1:2*AW];
  assign in_prior = s_tdata[3*AW+MS_W-1:2*AW+MS_W];
  assign dt_prod  = DT_PW'(in_ms) * DT_PW'(DT_RECIP) + DT_PW'(DT_RND);

  assign s_tready  = (state == S_IDLE);
  assign mul_start = (state == S_MUL_GO);
  assign div_start = (state == S_DIV_GO);
  assign div_num   = div_sel ? p10 : p00;
  assign mr        = XW'(mul_res);
  assign dt_op     = OPW'($signed({1'b0, dt}));
  assign s_comb    = (CW+1)'(p00) + (CW+1)'($signed({1'b0, r_meas}));

  // Operand routing for the shared multiplier
  always_comb begin
    unique case (op)
      OP_M0:   begin mul_a = dt_op; mul_b = OPW'(rate_q) - OPW'(gyro_bias); end
      OP_M1:   begin mul_a = dt_op; mul_b = OPW'(cov_ba) + OPW'(cov_ab);    end
      OP_M2:   begin mul_a = OPW'($signed({1'b0, q_angle})); mul_b = dt_op; end
      OP_M3:   begin mul_a = dt_op; mul_b = OPW'(cov_bb);                   end
      OP_M4:   begin mul_a = OPW'($signed({1'b0, q_bias})); mul_b = dt_op;  end
      OP_M5:   begin mul_a = OPW'(k0); mul_b = OPW'(y);   end
      OP_M6:   begin mul_a = OPW'(k1); mul_b = OPW'(y);   end
      OP_M7:   begin mul_a = OPW'(k0); mul_b = OPW'(p00); end
      OP_M8:   begin mul_a = OPW'(k0); mul_b = OPW'(p01); end
      OP_M9:   begin mul_a = OPW'(k1); mul_b = OPW'(p00); end
      OP_M10:  begin mul_a = OPW'(k1); mul_b = OPW'(p01); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Round working angle to Q.12, half away from zero, then saturate
  always_comb begin
    x_u   = x;
    x_mag = x_u[XA-1] ? (~x_u + XA'(1)) : x_u;
    x_rnd = (XA+1)'(x_mag) + (XA+1)'(1 << (ANGLE_SHIFT - 1));
    qm    = x_rnd[XA:ANGLE_SHIFT];
    if (x_u[XA-1]) begin
      out_val = (qm > OUT_NEG_LIM) ? OUT_MIN : AW'(~qm + QW'(1));
    end else begin
      out_val = (qm > OUT_POS_LIM) ? OUT_MAX : qm[AW-1:0];
    end
  end

  abkf_mul #(.OPW(OPW)) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (mul_start),
    .a      (mul_a),
    .b      (mul_b),
    .done   (mul_done),
    .result (mul_res)
  );

  abkf_div #(.CW(CW)) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (s_den),
    .done   (div_done),
    .result (div_res)
  );

  // Config writes; out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      q_angle <= ANGLE_NOISE_RST;
      q_bias  <= BIAS_NOISE_RST;
      r_meas  <= MEAS_NOISE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_ANGLE_NOISE: q_angle <= cfg_wdata;
        REG_BIAS_NOISE:  q_bias  <= cfg_wdata;
        REG_MEAS_NOISE:  r_meas  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_M0;
      div_sel   <= 1'b0;
      m_tvalid  <= 1'b0;
      gyro_bias <= '0;
      cov_aa    <= '0;
      cov_ab    <= '0;
      cov_ba    <= '0;
      cov_bb    <= '0;
    end else begin
      // the output step posts its own word when the old one leaves
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            meas_q <= {in_meas, {ANGLE_SHIFT{1'b0}}};
            rate_q <= {in_rate, {ANGLE_SHIFT{1'b0}}};
            x      <= {in_prior, {ANGLE_SHIFT{1'b0}}};
            dt     <= dt_prod[DT_PW-1:DT_SHIFT];
            op     <= OP_M0;
            state  <= S_MUL_GO;
          end
        end
        S_MUL_GO: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mul_done) begin
            state <= S_MUL_GO;
            unique case (op)
              OP_M0: begin x <= sat_xa(XW'(x) + mr); op <= OP_M1; end
              OP_M1: begin tmp <= XW'(cov_aa) - mr; op <= OP_M2; end
              OP_M2: begin p00 <= sat_cw(tmp + mr); op <= OP_M3; end
              OP_M3: begin
                p01 <= sat_cw(XW'(cov_ab) - mr);
                p10 <= sat_cw(XW'(cov_ba) - mr);
                op  <= OP_M4;
              end
              OP_M4: begin
                p11   <= sat_cw(XW'(cov_bb) + mr);
                state <= S_GAIN;
              end
              OP_M5: begin x <= sat_xa(XW'(x) + mr); op <= OP_M6; end
              OP_M6: begin gyro_bias <= sat_cw(XW'(gyro_bias) + mr); op <= OP_M7; end
              OP_M7: begin cov_aa <= sat_cw(XW'(p00) - mr); op <= OP_M8; end
              OP_M8: begin cov_ab <= sat_cw(XW'(p01) - mr); op <= OP_M9; end
              OP_M9: begin cov_ba <= sat_cw(XW'(p10) - mr); op <= OP_M10; end
              OP_M10: begin
                cov_bb <= sat_cw(XW'(p11) - mr);
                state  <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_GAIN: begin
          // innovation against the predicted angle; zero S means zero gains
          y     <= YW'(meas_q) - YW'(x);
          s_den <= s_comb;
          if (s_comb == '0) begin
            k0    <= '0;
            k1    <= '0;
            op    <= OP_M5;
            state <= S_MUL_GO;
          end else begin
            div_sel <= 1'b0;
            state   <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_done) begin
            if (!div_sel) begin
              k0      <= div_res;
              div_sel <= 1'b1;
              state   <= S_DIV_GO;
            end else begin
              k1    <= div_res;
              op    <= OP_M5;
              state <= S_MUL_GO;
            end
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= ODW'(out_val);
            m_tvalid <= 1'b1;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A word in flight blocks the next one
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second word accepted while busy");

  // The multiplier and divider are never started together
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  // Product results only arrive while the sequencer waits for them
  a_mul_done: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == S_MUL_WAIT))
    else $error("unexpected multiplier result");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV_WAIT))
    else $error("unexpected divider result");

  // A new result is only posted from the output step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state == S_OUT))
    else $error("result posted outside output step");

endmodule

`default_nettype wire

// ===== sim/angle_bias_kalman_filter_core_tb.sv =====
`default_nettype none

module angle_bias_kalman_filter_core_tb;
  import abkf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AW     = 16;
  localparam int CW     = 32;
  localparam int SD_W   = ((3*AW+MS_W+7)/8)*8;
  localparam int MD_W   = ((AW+7)/8)*8;
  localparam int WDOG   = 20000;
  localparam int DRAIN  = 400;   // extra idle clocks at the end of a drain
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;  // no register here
  localparam logic [63:0] MAG_CAP = 64'd1 << MAG_LIMIT_BITS;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [SD_W-1:0] s_tdata = '0;  // measured_angle, rate, interval_ms, prior_angle
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [MD_W-1:0] m_tdata;       // angle_out
  logic cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  angle_bias_kalman_filter_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------- filter predictor ----------------
  // model copy of the noise registers and the filter state
  logic [CFG_W-1:0] q_angle, q_bias, r_meas;
  longint bias_st, c00, c01, c10, c11;

  function automatic longint clip(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w-1)) - 1;
    lo = -hi - 1;
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  function automatic logic [63:0] absv(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic longint signed_cap(logic [63:0] m, bit neg);
    if (m > MAG_CAP) m = MAG_CAP;
    return neg ? -longint'(m) : longint'(m);
  endfunction

  // Q.24 product, rounded half away from zero
  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    logic [63:0] r;
    p = {64'd0, absv(a)} * {64'd0, absv(b)} + (128'd1 << (FRAC-1));
    if (p[127:64+FRAC] != 0) r = MAG_CAP;
    else r = p[63+FRAC:FRAC];
    return signed_cap(r, (a < 0) != (b < 0));
  endfunction

  // (num << 24) / den, truncated toward zero
  function automatic longint qdiv(longint num, longint den);
    logic [127:0] q;
    logic [63:0] r;
    q = ({64'd0, absv(num)} << FRAC) / {64'd0, absv(den)};
    if ((q >> 53) != 0) r = MAG_CAP;
    else r = q[63:0];
    return signed_cap(r, (num < 0) != (den < 0));
  endfunction

  function automatic logic [AW-1:0] filter_step(logic [SD_W-1:0] d);
    longint meas, rt, x, dt, p00, p01, p10, p11, y, s, k0, k1;
    logic [63:0] m;
    longint res;
    meas = longint'($signed(d[15:0])) * 4096;
    rt   = longint'($signed(d[31:16])) * 4096;
    dt   = longint'(({54'd0, d[41:32]} * DT_RECIP + DT_RND) >> DT_SHIFT);
    x    = longint'($signed(d[57:42])) * 4096;
    // predict
    x   = clip(x + qmul(dt, rt - bias_st), AW + 12);
    p00 = clip(c00 - qmul(dt, c10 + c01) + qmul(longint'(q_angle), dt), CW);
    p01 = clip(c01 - qmul(dt, c11), CW);
    p10 = clip(c10 - qmul(dt, c11), CW);
    p11 = clip(c11 + qmul(longint'(q_bias), dt), CW);
    // gain; zero S leaves both gains at zero
    y = meas - x;
    s = p00 + longint'(r_meas);
    if (s == 0) begin
      k0 = 0;
      k1 = 0;
    end else begin
      k0 = clip(qdiv(p00, s), CW);
      k1 = clip(qdiv(p10, s), CW);
    end
    // correct, with the pre-correction P00/P01
    x       = clip(x + qmul(k0, y), AW + 12);
    bias_st = clip(bias_st + qmul(k1, y), CW);
    c00     = clip(p00 - qmul(k0, p00), CW);
    c01     = clip(p01 - qmul(k0, p01), CW);
    c10     = clip(p10 - qmul(k1, p00), CW);
    c11     = clip(p11 - qmul(k1, p01), CW);
    m   = absv(x);
    res = longint'((m + 2048) >> 12);
    if (x < 0) res = -res;
    return AW'(clip(res, AW));
  endfunction

  // ---------------- scoreboard ----------------
  typedef struct packed {
    logic          fixed;   // a hand-typed value exists
    logic [AW-1:0] typed;
    logic [AW-1:0] pred;
  } angle_exp_t;

  angle_exp_t angle_q[$];
  logic          next_fixed = 1'b0;
  logic [AW-1:0] next_typed = '0;
  logic [AW-1:0] last_angle = '0;
  int errors = 0;
  int words_in = 0, words_out = 0, cfg_writes = 0;
  int idle_cnt = 0;
  int send_pct = 0, recv_pct = 0;

  always @(posedge clk) begin
    angle_exp_t e;
    if (rst) begin
      q_angle <= ANGLE_NOISE_RST;
      q_bias  <= BIAS_NOISE_RST;
      r_meas  <= MEAS_NOISE_RST;
      bias_st = 0; c00 = 0; c01 = 0; c10 = 0; c11 = 0;
    end else begin
      if (cfg_wr_en) begin
        cfg_writes++;
        case (cfg_addr)
          REG_ANGLE_NOISE: q_angle <= cfg_wdata;
          REG_BIAS_NOISE:  q_bias  <= cfg_wdata;
          REG_MEAS_NOISE:  r_meas  <= cfg_wdata;
          default: ;  // unused index, dropped
        endcase
      end
      if (s_tvalid && s_tready) begin
        e.fixed = next_fixed;
        e.typed = next_typed;
        e.pred  = filter_step(s_tdata);
        last_angle = e.pred;
        angle_q.push_back(e);
        words_in++;
      end
      if (m_tvalid && m_tready) begin
        words_out++;
        if (angle_q.size() == 0) begin
          $error("angle_out: unexpected word %h", m_tdata[AW-1:0]);
          errors++;
        end else begin
          e = angle_q.pop_front();
          if (m_tdata[AW-1:0] !== e.pred) begin
            $error("angle_out: expected %h, got %h", e.pred, m_tdata[AW-1:0]);
            errors++;
          end
          if (e.fixed && m_tdata[AW-1:0] !== e.typed) begin
            $error("angle_out: expected %h, got %h", e.typed, m_tdata[AW-1:0]);
            errors++;
          end
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_pct);
  end

  // watchdog: cycles with no handshake at all
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WDOG) begin
      $display("watchdog: no traffic for %0d cycles", WDOG);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  function automatic logic [SD_W-1:0] pack_word(logic [15:0] meas, logic [15:0] rt,
                                                logic [9:0] ms, logic [15:0] prior);
    return SD_W'({prior, ms, rt, meas});
  endfunction

  task automatic send_word(logic [SD_W-1:0] d);
    while ($urandom_range(99) < send_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
  endtask

  // settle everything before touching a register
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (angle_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_ADDR_W-1:0] a, logic [CFG_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= a;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  typedef struct {
    logic [15:0] meas, rt;
    logic [9:0]  ms;
    logic [15:0] prior;
    bit          fixed;
    logic [15:0] angle;
  } row_t;

  // zero interval right after reset: P stays zero, so the gain is zero and
  // the prior angle comes straight back
  row_t dir_rows[] = '{
    '{16'h0000, 16'h0000, 10'd0,    16'h0000, 1, 16'h0000},
    '{16'h7fff, 16'h7fff, 10'd0,    16'h7fff, 1, 16'h7fff},
    '{16'h8000, 16'h8000, 10'd0,    16'h8000, 1, 16'h8000},
    '{16'h7fff, 16'h8000, 10'd0,    16'h8000, 1, 16'h8000},
    '{16'h8000, 16'h7fff, 10'd0,    16'h1234, 1, 16'h1234},
    '{16'h0800, 16'h0100, 10'd10,   16'h0000, 0, 16'h0000},
    '{16'h7fff, 16'h7fff, 10'd1023, 16'h7fff, 0, 16'h0000},
    '{16'h8000, 16'h8000, 10'd1023, 16'h8000, 0, 16'h0000},
    '{16'h7fff, 16'h8000, 10'd1023, 16'h8000, 0, 16'h0000},
    '{16'h8000, 16'h7fff, 10'd1023, 16'h7fff, 0, 16'h0000},
    '{16'h0000, 16'h0000, 10'd1,    16'h0000, 0, 16'h0000},
    '{16'h1000, 16'hf000, 10'd20,   16'h0f00, 0, 16'h0000},
    '{16'hc000, 16'h2000, 10'd512,  16'h4000, 0, 16'h0000},
    '{16'h0001, 16'hffff, 10'd0,    16'hffff, 0, 16'h0000},
    '{16'h5555, 16'haaaa, 10'd341,  16'haaaa, 0, 16'h0000},
    '{16'haaaa, 16'h5555, 10'd682,  16'h5555, 0, 16'h0000}
  };

  task automatic random_phase(int n);
    logic [15:0] meas, rt, prior;
    logic [9:0]  ms;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 70) begin
        // typical loop: short interval, modest angles, fed-back estimate
        ms    = 10'($urandom_range(40));
        rt    = 16'($signed(16'($urandom_range(4096))) - 16'sd2048);
        meas  = 16'($signed(16'($urandom_range(16384))) - 16'sd8192);
        prior = last_angle;
      end else begin
        ms    = 10'($urandom);
        rt    = 16'($urandom);
        meas  = 16'($urandom);
        prior = 16'($urandom);
      end
      next_fixed <= 1'b0;
      send_word(pack_word(meas, rt, ms, prior));
      // hold off once until the pipe is empty
      if (i == n/2) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (angle_q.size() != 0) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table, no idling
    foreach (dir_rows[i]) begin
      next_fixed <= dir_rows[i].fixed;
      next_typed <= dir_rows[i].angle;
      send_word(pack_word(dir_rows[i].meas, dir_rows[i].rt, dir_rows[i].ms,
                          dir_rows[i].prior));
    end
    next_fixed <= 1'b0;

    // phase: defaults, no idling
    random_phase(250);
    drain();
    // largest noise values; unused index must be dropped
    write_reg(REG_ANGLE_NOISE, 24'hffffff);
    write_reg(REG_BIAS_NOISE, 24'hffffff);
    write_reg(REG_MEAS_NOISE, 24'hffffff);
    write_reg(REG_UNUSED, 24'h000001);
    send_pct = 71; recv_pct = 0;
    random_phase(250);
    drain();
    // smallest legal noise values
    write_reg(REG_ANGLE_NOISE, 24'h000000);
    write_reg(REG_BIAS_NOISE, 24'h000000);
    write_reg(REG_MEAS_NOISE, 24'h000001);
    send_pct = 0; recv_pct = 71;
    random_phase(250);
    drain();
    write_reg(REG_ANGLE_NOISE, 24'($urandom));
    write_reg(REG_BIAS_NOISE, 24'($urandom));
    write_reg(REG_MEAS_NOISE, 24'($urandom_range(24'hffffff, 1)));
    send_pct = 15; recv_pct = 15;
    random_phase(300);
    drain();
    write_reg(REG_ANGLE_NOISE, ANGLE_NOISE_RST);
    write_reg(REG_BIAS_NOISE, BIAS_NOISE_RST);
    write_reg(REG_MEAS_NOISE, MEAS_NOISE_RST);
    send_pct = 0; recv_pct = 0;
    random_phase(250);
    drain();

    $display("covered %0d words in, %0d out, %0d register writes", words_in, words_out,
             cfg_writes);
    $display("noise settings: defaults, maximum, minimum, random; four idling mixes");
    if (errors == 0 && angle_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
